FILE: rtl/core/tcg_pkg.sv
// Shared constants and widths of the text cell glyph renderer.
`timescale 1ns / 1ps
package tcg_pkg;

    localparam int GLYPH_WIDTH    = 5;
    localparam int GLYPH_HEIGHT   = 9;
    localparam int FONT_CHARS_DEF = 96;
    localparam int FONT_DEPTH_DEF = FONT_CHARS_DEF * GLYPH_HEIGHT;
    localparam int QUEUE_DEPTH    = 4;

    localparam int ADDR_W  = 32;
    localparam int COLOR_W = 32;
    localparam int LW_W    = 13;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int CODE_W  = 8;
    localparam int GROW_W  = 4;
    localparam int BITS_W  = 5;
    localparam int XC_W    = 3;
    localparam int YC_W    = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CODE_W-1:0]  FIRST_CODE = 8'd32;
    localparam logic [COLOR_W-1:0] COLOR_FG   = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] COLOR_BG   = 32'h5555_0000;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PUT  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS       = 4'd3;

    localparam logic [ADDR_W-1:0] RST_BASE       = 32'd0;
    localparam logic [LW_W-1:0]   RST_LINE_WIDTH = 13'd640;
    localparam logic [COL_W-1:0]  RST_COLUMNS    = 10'd128;
    localparam logic [ROW_W-1:0]  RST_ROWS       = 9'd53;

endpackage

FILE: rtl/core/tcg_if.sv
// Channel interfaces of the renderer: character input, pixel output, configuration.
`timescale 1ns / 1ps
interface tcg_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [tcg_pkg::CODE_W-1:0]  char_code;
    logic [tcg_pkg::GROW_W-1:0]  glyph_row;
    logic [tcg_pkg::BITS_W-1:0]  row_bits;

    modport source (output valid, op, char_code, glyph_row, row_bits, input ready);
    modport sink   (input valid, op, char_code, glyph_row, row_bits, output ready);
endinterface

interface tcg_out_if;
    logic                        valid;
    logic                        ready;
    logic [tcg_pkg::ADDR_W-1:0]  pixel_address;
    logic [tcg_pkg::COLOR_W-1:0] pixel_color;
    logic                        last_pixel;

    modport source (output valid, pixel_address, pixel_color, last_pixel, input ready);
    modport sink   (input valid, pixel_address, pixel_color, last_pixel, output ready);
endinterface

interface tcg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tcg_pkg::CFG_IDX_W-1:0]  index;
    logic [tcg_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/tcg_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module tcg_ram #(
    parameter int WIDTH = tcg_pkg::BITS_W,
    parameter int DEPTH = tcg_pkg::FONT_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: rtl/core/tcg_queue.sv
// Small first-in first-out queue between the front and back parts.
`timescale 1ns / 1ps
module tcg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tcg_pkg::QUEUE_DEPTH,
    localparam int PW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);
    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_slot[r_rd_ptr];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end
endmodule

FILE: rtl/core/tcg_front.sv
// Front part: accepts input items, classifies them and forms font store addresses.
`timescale 1ns / 1ps
module tcg_front #(
    parameter int FONT_CHARS = tcg_pkg::FONT_CHARS_DEF,
    localparam int FA_W  = $clog2(FONT_CHARS * tcg_pkg::GLYPH_HEIGHT),
    localparam int CMD_W = FA_W + 2 + tcg_pkg::BITS_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tcg_in_if.sink           i_in,
    output logic             o_push_valid,
    input  logic             i_push_ready,
    output logic [CMD_W-1:0] o_push_data
);
    import tcg_pkg::*;

    localparam int GF_W = CODE_W + GROW_W;

    typedef struct packed {
        logic              is_put;
        logic              has_glyph;
        logic [FA_W-1:0]   gaddr;
        logic [BITS_W-1:0] row_bits;
    } t_cmd;

    logic [CODE_W-1:0] code_off;
    logic [GF_W-1:0]   gfull;
    logic              is_put, has_glyph, row_ok, keep, accept, push;
    logic              r_valid, n_valid;
    t_cmd              cmd, r_cmd;

    assign is_put    = (i_in.op == OP_PUT);
    assign code_off  = i_in.char_code - FIRST_CODE;
    assign has_glyph = (i_in.char_code >= FIRST_CODE)
                    && ({1'b0, code_off} < (CODE_W + 1)'(FONT_CHARS));
    assign row_ok    = (i_in.glyph_row < GROW_W'(GLYPH_HEIGHT));
    assign gfull     = GF_W'(code_off) * GF_W'(GLYPH_HEIGHT)
                     + (is_put ? GF_W'(0) : GF_W'(i_in.glyph_row));
    assign keep      = is_put || (has_glyph && row_ok);

    always_comb begin
        cmd.is_put    = is_put;
        cmd.has_glyph = has_glyph;
        cmd.gaddr     = gfull[FA_W-1:0];
        cmd.row_bits  = i_in.row_bits;
    end

    assign i_in.ready = !r_valid || i_push_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign push       = r_valid && i_push_ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = keep;
        end else if (push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= cmd;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_data  = r_cmd;
endmodule

FILE: rtl/core/tcg_back.sv
// Back part: configuration, cursor, font store access and pixel generation.
`timescale 1ns / 1ps
module tcg_back #(
    parameter int FONT_CHARS = tcg_pkg::FONT_CHARS_DEF,
    localparam int FA_W  = $clog2(FONT_CHARS * tcg_pkg::GLYPH_HEIGHT),
    localparam int CMD_W = FA_W + 2 + tcg_pkg::BITS_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tcg_cfg_if.sink                    i_cfg,
    input  logic                       i_pop_valid,
    output logic                       o_pop_ready,
    input  logic [CMD_W-1:0]           i_pop_data,
    output logic                       o_wr_en,
    output logic [FA_W-1:0]            o_wr_addr,
    output logic [tcg_pkg::BITS_W-1:0] o_wr_data,
    output logic                       o_rd_en,
    output logic [FA_W-1:0]            o_rd_addr,
    input  logic [tcg_pkg::BITS_W-1:0] i_rd_data,
    tcg_out_if.source                  o_out
);
    import tcg_pkg::*;

    localparam int RP_W   = 13;
    localparam int PROD_W = RP_W + LW_W;
    localparam int CP_W   = 15;
    localparam int STR_W  = LW_W + 2;
    localparam logic [XC_W-1:0] X_LAST = XC_W'(GLYPH_WIDTH - 1);
    localparam logic [YC_W-1:0] Y_LAST = YC_W'(GLYPH_HEIGHT - 1);

    typedef struct packed {
        logic              is_put;
        logic              has_glyph;
        logic [FA_W-1:0]   gaddr;
        logic [BITS_W-1:0] row_bits;
    } t_cmd;

    t_cmd head;

    logic [ADDR_W-1:0] r_base, n_base;
    logic [LW_W-1:0]   r_lw, n_lw;
    logic [COL_W-1:0]  r_cols, n_cols;
    logic [ROW_W-1:0]  r_rows, n_rows;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [1:0]        r_settle, n_settle;

    logic [RP_W-1:0]   rowpix;
    logic [PROD_W-1:0] r_prod;
    logic [CP_W-1:0]   r_colpart;
    logic [ADDR_W-1:0] r_next_cell;
    logic [ADDR_W-1:0] stride32;

    logic              r_active, n_active;
    logic [XC_W-1:0]   r_x, n_x;
    logic [YC_W-1:0]   r_y, n_y;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [ADDR_W-1:0] r_line, n_line;
    logic [FA_W-1:0]   r_gaddr, n_gaddr;
    logic              r_glyph, n_glyph;
    logic              r_fresh;
    logic [BITS_W-1:0] r_row_bits, cur_row;

    logic               r_ovalid;
    logic [ADDR_W-1:0]  r_oaddr;
    logic [COLOR_W-1:0] r_ocolor;
    logic               r_olast;

    logic              cfg_wr, out_free, emit, row_end, cell_end, slot_free;
    logic              pop, put_do, load_do, pix_bit;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic [XC_W-1:0]   bit_idx;

    assign head     = t_cmd'(i_pop_data);
    assign stride32 = ADDR_W'({r_lw, 2'b00});

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    assign out_free  = !r_ovalid || o_out.ready;
    assign emit      = r_active && out_free;
    assign row_end   = emit && (r_x == X_LAST);
    assign cell_end  = row_end && (r_y == Y_LAST);
    assign slot_free = !r_active || cell_end;

    assign o_pop_ready = slot_free && (!head.is_put || (r_settle == 2'd0));
    assign pop         = i_pop_valid && o_pop_ready;
    assign put_do      = pop && head.is_put;
    assign load_do     = pop && !head.is_put;

    assign o_wr_en   = load_do;
    assign o_wr_addr = head.gaddr;
    assign o_wr_data = head.row_bits;
    assign o_rd_en   = (put_do && head.has_glyph) || (row_end && !cell_end && r_glyph);
    assign o_rd_addr = put_do ? head.gaddr : r_gaddr + 1'b1;

    assign cur_row = r_glyph ? (r_fresh ? i_rd_data : r_row_bits) : '0;
    assign bit_idx = X_LAST - r_x;
    assign pix_bit = cur_row[bit_idx];

    assign rowpix  = RP_W'(r_row) * RP_W'(GLYPH_HEIGHT);
    assign col_inc = {1'b0, r_col} + 1'b1;
    assign row_inc = {1'b0, r_row} + 1'b1;

    always_comb begin
        n_base = r_base;
        n_lw   = r_lw;
        n_cols = r_cols;
        n_rows = r_rows;
        if (cfg_wr) begin
            case (i_cfg.index)
                CFG_BASE:       n_base = i_cfg.data[ADDR_W-1:0];
                CFG_LINE_WIDTH: n_lw   = i_cfg.data[LW_W-1:0];
                CFG_COLUMNS:    n_cols = i_cfg.data[COL_W-1:0];
                CFG_ROWS:       n_rows = i_cfg.data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_settle = (r_settle != 2'd0) ? r_settle - 1'b1 : r_settle;
        if (put_do) begin
            if (col_inc >= {1'b0, r_cols}) begin
                n_col = '0;
                n_row = (row_inc >= {1'b0, r_rows}) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end
        // The cell address pipeline must settle after any change of its inputs.
        if (put_do || cfg_wr) begin
            n_settle = 2'd2;
        end
    end

    always_comb begin
        n_active = r_active;
        n_x      = r_x;
        n_y      = r_y;
        n_addr   = r_addr;
        n_line   = r_line;
        n_gaddr  = r_gaddr;
        n_glyph  = r_glyph;
        if (put_do) begin
            n_active = 1'b1;
            n_x      = '0;
            n_y      = '0;
            n_addr   = r_next_cell;
            n_line   = r_next_cell;
            n_gaddr  = head.gaddr;
            n_glyph  = head.has_glyph;
        end else if (cell_end) begin
            n_active = 1'b0;
        end else if (row_end) begin
            n_x     = '0;
            n_y     = r_y + 1'b1;
            n_addr  = r_line + stride32;
            n_line  = r_line + stride32;
            n_gaddr = r_gaddr + 1'b1;
        end else if (emit) begin
            n_x    = r_x + 1'b1;
            n_addr = r_addr + ADDR_W'(4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= RST_BASE;
            r_lw     <= RST_LINE_WIDTH;
            r_cols   <= RST_COLUMNS;
            r_rows   <= RST_ROWS;
            r_col    <= '0;
            r_row    <= '0;
            r_settle <= 2'd2;
            r_active <= 1'b0;
            r_fresh  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_base   <= n_base;
            r_lw     <= n_lw;
            r_cols   <= n_cols;
            r_rows   <= n_rows;
            r_col    <= n_col;
            r_row    <= n_row;
            r_settle <= n_settle;
            r_active <= n_active;
            r_fresh  <= o_rd_en;
            if (out_free) begin
                r_ovalid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod      <= PROD_W'(rowpix) * PROD_W'(r_lw);
        r_colpart   <= CP_W'(r_col) * CP_W'(GLYPH_WIDTH * 4);
        r_next_cell <= r_base + ADDR_W'(r_colpart) + ADDR_W'({r_prod, 2'b00});
        r_x         <= n_x;
        r_y         <= n_y;
        r_addr      <= n_addr;
        r_line      <= n_line;
        r_gaddr     <= n_gaddr;
        r_glyph     <= n_glyph;
        r_row_bits  <= cur_row;
        if (emit) begin
            r_oaddr  <= r_addr;
            r_ocolor <= pix_bit ? COLOR_FG : COLOR_BG;
            r_olast  <= cell_end;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.pixel_address = r_oaddr;
    assign o_out.pixel_color   = r_ocolor;
    assign o_out.last_pixel    = r_olast;

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_end |=> (o_out.valid && o_out.last_pixel))
        else $error("Final pixel of a cell was not flagged.");

    a_cursor_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        put_do |=> ((r_col == '0) || (r_col == $past(r_col) + 1'b1)))
        else $error("Cursor column moved by other than one cell.");

    a_counter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> ((r_x <= X_LAST) && (r_y <= Y_LAST)))
        else $error("Pixel counters left the glyph cell.");

    a_read_in_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh |-> r_active)
        else $error("Font row arrived while no cell was being drawn.");
endmodule

FILE: rtl/core/text_cell_glyph_renderer.sv
// Top level of the text cell glyph renderer.
//
//  Port      Direction  Transfer carries
//  i_in      sink       op, char_code, glyph_row, row_bits
//  o_out     source     pixel_address, pixel_color, last_pixel
//  i_cfg     sink       index, data (register write, always ready)
//
// Pixels leave one per cycle while o_out is ready, set by the single pixel output
// register; the first font row read overlaps the last pixel of the previous cell.
// A font load is written to the font store as the back part pops it. A character
// that follows a configuration write waits for the cell address multiplier to settle.
// Reset clears the cursor and presets config; the font store holds nothing until loaded.
// A queue of Q_DEPTH items lets input transfers continue while the output stalls.
`timescale 1ns / 1ps
module text_cell_glyph_renderer #(
    parameter int FONT_CHARS = tcg_pkg::FONT_CHARS_DEF,
    parameter int Q_DEPTH    = tcg_pkg::QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcg_in_if.sink    i_in,
    tcg_cfg_if.sink   i_cfg,
    tcg_out_if.source o_out
);
    import tcg_pkg::*;

    localparam int DEPTH = FONT_CHARS * GLYPH_HEIGHT;
    localparam int FA_W  = $clog2(DEPTH);
    localparam int CMD_W = FA_W + 2 + BITS_W;

    logic              push_valid, push_ready, pop_valid, pop_ready;
    logic [CMD_W-1:0]  push_data, pop_data;
    logic              wr_en, rd_en;
    logic [FA_W-1:0]   wr_addr, rd_addr;
    logic [BITS_W-1:0] wr_data, rd_data;

    tcg_front #(.FONT_CHARS(FONT_CHARS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    tcg_queue #(.WIDTH(CMD_W), .DEPTH(Q_DEPTH)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    tcg_ram #(.WIDTH(BITS_W), .DEPTH(DEPTH)) u_font (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tcg_back #(.FONT_CHARS(FONT_CHARS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_out       (o_out)
    );
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the text cell glyph renderer: font loads, drawn cells, wraps.
`timescale 1ns / 1ps
module testbench;
    import tcg_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int CELL_PIXELS   = GLYPH_WIDTH * GLYPH_HEIGHT;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_write_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcg_in_if  char_bus ();
    tcg_out_if pix_bus ();
    tcg_cfg_if cfg_bus ();

    text_cell_glyph_renderer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_bus),
        .i_cfg   (cfg_bus),
        .o_out   (pix_bus)
    );

    logic [ADDR_W-1:0] cfg_base;
    logic [LW_W-1:0]   cfg_line_width;
    logic [COL_W-1:0]  cfg_columns;
    logic [ROW_W-1:0]  cfg_rows;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;

    logic [BITS_W-1:0] font_rows [FONT_DEPTH_DEF];
    bit                row_loaded [FONT_DEPTH_DEF];
    bit                glyph_ready [FONT_CHARS_DEF];
    int                drawable_codes [$];

    pixel_write_t pending_pixels [$];
    int error_count = 0;
    int stall_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;

    always #5 i_clk = ~i_clk;

    function automatic bit load_hits_store(input logic [CODE_W-1:0] code,
                                           input logic [GROW_W-1:0] grow);
        int c;
        c = int'(code);
        return c >= int'(FIRST_CODE) && c < int'(FIRST_CODE) + FONT_CHARS_DEF
               && int'(grow) < GLYPH_HEIGHT;
    endfunction

    function automatic void apply_font_load(input logic [CODE_W-1:0] code,
                                            input logic [GROW_W-1:0] grow,
                                            input logic [BITS_W-1:0] bits);
        int glyph;
        bit complete;
        if (!load_hits_store(code, grow))
            return;
        glyph = int'(code) - int'(FIRST_CODE);
        font_rows[glyph * GLYPH_HEIGHT + int'(grow)] = bits;
        row_loaded[glyph * GLYPH_HEIGHT + int'(grow)] = 1'b1;
        complete = 1'b1;
        for (int r = 0; r < GLYPH_HEIGHT; r++)
            complete &= row_loaded[glyph * GLYPH_HEIGHT + r];
        if (complete && !glyph_ready[glyph]) begin
            glyph_ready[glyph] = 1'b1;
            drawable_codes.push_back(int'(code));
        end
    endfunction

    // Queues the 45 pixel writes of one cell, then steps the cursor.
    function automatic void render_cell(input logic [CODE_W-1:0] code);
        logic [ADDR_W-1:0] stride;
        logic [ADDR_W-1:0] cell_addr;
        logic [ADDR_W-1:0] col_next;
        logic [ADDR_W-1:0] row_next;
        logic [BITS_W-1:0] bits;
        pixel_write_t      px;
        bit                has_glyph;
        int                glyph;
        has_glyph = int'(code) >= int'(FIRST_CODE)
                    && int'(code) < int'(FIRST_CODE) + FONT_CHARS_DEF;
        glyph = has_glyph ? int'(code) - int'(FIRST_CODE) : 0;
        stride = ADDR_W'(cfg_line_width) << 2;
        cell_addr = cfg_base + ADDR_W'(cur_col) * ADDR_W'(GLYPH_WIDTH * 4)
                    + ADDR_W'(cur_row) * ADDR_W'(GLYPH_HEIGHT) * stride;
        for (int y = 0; y < GLYPH_HEIGHT; y++) begin
            bits = has_glyph ? font_rows[glyph * GLYPH_HEIGHT + y] : '0;
            for (int x = 0; x < GLYPH_WIDTH; x++) begin
                px.addr  = cell_addr + ADDR_W'(y) * stride + ADDR_W'(4 * x);
                px.color = bits[GLYPH_WIDTH - 1 - x] ? COLOR_FG : COLOR_BG;
                px.last  = (y * GLYPH_WIDTH + x == CELL_PIXELS - 1);
                pending_pixels.push_back(px);
            end
        end
        col_next = ADDR_W'(cur_col) + 1;
        if (col_next >= ADDR_W'(cfg_columns)) begin
            row_next = ADDR_W'(cur_row) + 1;
            col_next = '0;
            if (row_next >= ADDR_W'(cfg_rows))
                row_next = '0;
            cur_row = row_next[ROW_W-1:0];
        end
        cur_col = col_next[COL_W-1:0];
    endfunction

    task automatic send_item(input logic op, input logic [CODE_W-1:0] code,
                             input logic [GROW_W-1:0] grow, input logic [BITS_W-1:0] bits);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            char_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        char_bus.valid     = 1'b1;
        char_bus.op        = op;
        char_bus.char_code = code;
        char_bus.glyph_row = grow;
        char_bus.row_bits  = bits;
        do @(posedge i_clk); while (!char_bus.ready);
        if (op == OP_PUT)
            render_cell(code);
        else
            apply_font_load(code, grow, bits);
    endtask

    task automatic put_char(input logic [CODE_W-1:0] code);
        send_item(OP_PUT, code, GROW_W'($urandom_range(15)), BITS_W'($urandom()));
    endtask

    task automatic drain;
        @(negedge i_clk);
        char_bus.valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            CFG_BASE:       cfg_base       = data[ADDR_W-1:0];
            CFG_LINE_WIDTH: cfg_line_width = data[LW_W-1:0];
            CFG_COLUMNS:    cfg_columns    = data[COL_W-1:0];
            CFG_ROWS:       cfg_rows       = data[ROW_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic set_config(input logic [ADDR_W-1:0] base, input int line_width,
                              input int columns, input int rows);
        write_reg(CFG_BASE, base);
        write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(line_width));
        write_reg(CFG_COLUMNS, CFG_DATA_W'(columns));
        write_reg(CFG_ROWS, CFG_DATA_W'(rows));
    endtask

    function automatic logic [CODE_W-1:0] pick_put_code;
        if (drawable_codes.size() == 0 || $urandom_range(99) < 20)
            return $urandom_range(1) ? CODE_W'($urandom_range(int'(FIRST_CODE) - 1))
                                     : CODE_W'($urandom_range(255, 128));
        return CODE_W'(drawable_codes[$urandom_range(drawable_codes.size() - 1)]);
    endfunction

    task automatic test_font_load;
        logic [BITS_W-1:0] space_rows [GLYPH_HEIGHT] =
            '{5'h1F, 5'h00, 5'h10, 5'h01, 5'h15, 5'h0A, 5'h11, 5'h0E, 5'h1F};
        logic [BITS_W-1:0] tilde_rows [GLYPH_HEIGHT] =
            '{5'h0A, 5'h15, 5'h1F, 5'h04, 5'h00, 5'h1B, 5'h08, 5'h02, 5'h11};
        for (int r = 0; r < GLYPH_HEIGHT; r++)
            send_item(OP_LOAD, FIRST_CODE, GROW_W'(r), space_rows[r]);
        for (int r = GLYPH_HEIGHT - 1; r >= 0; r--)
            send_item(OP_LOAD, 8'd127, GROW_W'(r), tilde_rows[r]);
        send_item(OP_LOAD, 8'd31, 4'd0, 5'h1F);
        send_item(OP_LOAD, 8'd128, 4'd3, 5'h1F);
        send_item(OP_LOAD, 8'd40, 4'd9, 5'h1F);
        send_item(OP_LOAD, 8'd255, 4'd15, 5'h1F);
        drain();
    endtask

    task automatic test_black_and_glyph_cells;
        put_char(FIRST_CODE);
        put_char(8'd127);
        put_char(8'd0);
        put_char(8'd255);
        put_char(8'd31);
        put_char(8'd128);
        drain();
    endtask

    task automatic test_cursor_limits;
        write_reg(CFG_COLUMNS, 819);
        write_reg(CFG_ROWS, 455);
        repeat (4) put_char(FIRST_CODE);
        drain();
        write_reg(CFG_COLUMNS, 2);
        repeat (3) put_char(8'd127);
        drain();
        write_reg(CFG_COLUMNS, 0);
        write_reg(CFG_ROWS, 0);
        repeat (2) put_char(FIRST_CODE);
        drain();
    endtask

    task automatic test_address_overflow;
        set_config(32'hFFFF_FFE0, 4096, 819, 455);
        put_char(8'd127);
        put_char(FIRST_CODE);
        drain();
    endtask

    task automatic test_output_backpressure;
        hold_left = HOLD_CYCLES;
        repeat (10) put_char(pick_put_code());
        drain();
    endtask

    task automatic run_random_traffic(input int n_items);
        int                sent;
        int                choice;
        logic [CODE_W-1:0] code;
        logic [GROW_W-1:0] grow;
        sent = 0;
        while (sent < n_items) begin
            choice = $urandom_range(99);
            if (choice < 55) begin
                put_char(pick_put_code());
                sent++;
            end else if (choice < 80) begin
                code = CODE_W'($urandom_range(int'(FIRST_CODE) + FONT_CHARS_DEF - 1,
                                              int'(FIRST_CODE)));
                for (int r = 0; r < GLYPH_HEIGHT; r++)
                    send_item(OP_LOAD, code, GROW_W'(r), BITS_W'($urandom()));
                sent += GLYPH_HEIGHT;
            end else begin
                code = CODE_W'($urandom_range(255));
                grow = GROW_W'($urandom_range(15));
                send_item(OP_LOAD, code, grow, BITS_W'($urandom()));
                sent++;
            end
        end
        drain();
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            pix_bus.ready = 1'b0;
            hold_left--;
        end else begin
            pix_bus.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        pixel_write_t want;
        if (i_rst_n && pix_bus.valid && pix_bus.ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel transfer addr %h color %h last %b", $time,
                         pix_bus.pixel_address, pix_bus.pixel_color, pix_bus.last_pixel);
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (pix_bus.pixel_address !== want.addr) begin
                    $display("%0t: pixel_address expected %h got %h", $time,
                             want.addr, pix_bus.pixel_address);
                    error_count++;
                end
                if (pix_bus.pixel_color !== want.color) begin
                    $display("%0t: pixel_color expected %h got %h", $time,
                             want.color, pix_bus.pixel_color);
                    error_count++;
                end
                if (pix_bus.last_pixel !== want.last) begin
                    $display("%0t: last_pixel expected %b got %b", $time,
                             want.last, pix_bus.last_pixel);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((char_bus.valid && char_bus.ready) || (pix_bus.valid && pix_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("text_cell_glyph_renderer: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        char_bus.valid     = 1'b0;
        char_bus.op        = OP_LOAD;
        char_bus.char_code = '0;
        char_bus.glyph_row = '0;
        char_bus.row_bits  = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = CFG_BASE;
        cfg_bus.data       = '0;
        pix_bus.ready      = 1'b0;
        cfg_base           = RST_BASE;
        cfg_line_width     = RST_LINE_WIDTH;
        cfg_columns        = RST_COLUMNS;
        cfg_rows           = RST_ROWS;
        cur_col            = '0;
        cur_row            = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 66;
        test_font_load();
        test_black_and_glyph_cells();
        test_cursor_limits();
        test_address_overflow();
        test_output_backpressure();

        set_config($urandom(), $urandom_range(4096, 5), $urandom_range(819, 1),
                   $urandom_range(455, 1));
        run_random_traffic(60);

        send_idle_pct = 66;
        recv_idle_pct = 28;
        set_config(32'hFFFF_F000, 4096, 1, 455);
        run_random_traffic(60);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(32'h0000_0000, 5, 3, 2);
        run_random_traffic(60);

        if (pending_pixels.size() != 0) begin
            $display("%0t: %0d expected pixel writes never arrived", $time,
                     pending_pixels.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("text_cell_glyph_renderer: match");
        end else begin
            $display("text_cell_glyph_renderer: mismatch");
        end
        $finish;
    end

endmodule

FILE: text_cell_glyph_renderer.f
rtl/core/tcg_pkg.sv
rtl/core/tcg_if.sv
rtl/core/tcg_ram.sv
rtl/core/tcg_queue.sv
rtl/core/tcg_front.sv
rtl/core/tcg_back.sv
rtl/core/text_cell_glyph_renderer.sv
tb/testbench.sv
